// ----- sv/eefc_pkg.sv -----
`timescale 1ns / 1ps
package eefc_pkg;

	// pinhole constants in Q16.16, rounded to nearest
	localparam logic [23:0] FOCAL_Q = 24'd11645878;
	localparam logic [23:0] PPX_Q   = 24'd10207691;
	localparam logic [23:0] PPY_Q   = 24'd7440892;

	// displacement clamp, 2^24 pixels in Q16.16
	localparam logic [40:0] DISP_CAP = 41'h100_0000_0000;

	// divider: dividend magnitude bits and quotient bits kept
	localparam int DIV_W = 50;
	localparam int QUO_W = 27;

	// floor(2^DIV_W / FOCAL_Q); a quotient estimate with it is short by at most one
	localparam logic [26:0] FOCAL_RECIP = 27'((64'd1 << DIV_W) / 64'(FOCAL_Q));

	// configuration register indexes
	localparam logic [3:0] REG_TRANS_VX  = 4'd0;
	localparam logic [3:0] REG_TRANS_VY  = 4'd1;
	localparam logic [3:0] REG_TRANS_VZ  = 4'd2;
	localparam logic [3:0] REG_ROT_VX    = 4'd3;
	localparam logic [3:0] REG_ROT_VY    = 4'd4;
	localparam logic [3:0] REG_ROT_VZ    = 4'd5;
	localparam logic [3:0] REG_FULL_MOT  = 4'd6;
	localparam logic [3:0] REG_TICK_SCL  = 4'd7;

	typedef struct packed {
		logic signed [31:0] tvx;
		logic signed [31:0] tvy;
		logic signed [31:0] tvz;
		logic signed [31:0] rvx;
		logic signed [31:0] rvy;
		logic signed [31:0] rvz;
		logic               full_motion;
		logic [31:0]        tick_scale;
	} eefc_cfg_t;

	// one queued item as classified by the front
	typedef struct packed {
		logic               cmd;
		logic [8:0]         x;
		logic [7:0]         y;
		logic [31:0]        diff;
		logic signed [25:0] dx;
		logic signed [24:0] dy;
		logic               o_in;
	} eefc_item_t;

endpackage

// ----- sv/event_ego_flow_compensation_top.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     command, event_x, event_y, event_stamp
// out       output     out_valid / out_ready   flow_x, flow_y, warped_x, warped_y,
//                                              warped_inside, original_inside,
//                                              hit_count, repeat_hit
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// an event passes the back end as 18 products through one shared 33x33 multiplier,
// three reciprocal divides by the focal constant, and eight steps (pop, coefficients,
// flow, warp, address, read, write, output)
// a new-batch command holds the back end while the count map is swept to zero; the
// same sweep runs after reset, with in_ready low
// a two entry queue sits between front and back, and the output register lets the
// back end start the next item while a result waits for its transfer
module event_ego_flow_compensation_top #(
	parameter int IMAGE_WIDTH  = 304,
	parameter int IMAGE_HEIGHT = 240
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [8:0]         event_x,
	input  logic [7:0]         event_y,
	input  logic [31:0]        event_stamp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] flow_x,
	output logic signed [31:0] flow_y,
	output logic signed [15:0] warped_x,
	output logic signed [15:0] warped_y,
	output logic               warped_inside,
	output logic               original_inside,
	output logic [7:0]         hit_count,
	output logic               repeat_hit,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import eefc_pkg::*;

	eefc_cfg_t  cfg_q;
	eefc_item_t q_in;
	eefc_item_t q_out;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	logic       init_busy;

	// register writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tvx         <= '0;
			cfg_q.tvy         <= '0;
			cfg_q.tvz         <= '0;
			cfg_q.rvx         <= '0;
			cfg_q.rvy         <= '0;
			cfg_q.rvz         <= '0;
			cfg_q.full_motion <= 1'b1;
			cfg_q.tick_scale  <= 32'd344;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TRANS_VX: cfg_q.tvx         <= cfg_data;
				REG_TRANS_VY: cfg_q.tvy         <= cfg_data;
				REG_TRANS_VZ: cfg_q.tvz         <= cfg_data;
				REG_ROT_VX:   cfg_q.rvx         <= cfg_data;
				REG_ROT_VY:   cfg_q.rvy         <= cfg_data;
				REG_ROT_VZ:   cfg_q.rvz         <= cfg_data;
				REG_FULL_MOT: cfg_q.full_motion <= cfg_data[0];
				REG_TICK_SCL: cfg_q.tick_scale  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: reference stamp, centred coordinates, border test of the event itself
	eefc_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.event_x     (event_x),
		.event_y     (event_y),
		.event_stamp (event_stamp),
		.init_busy   (init_busy),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	eefc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (q_out)
	);

	// back: motion field, warp, count map and output register
	eefc_back #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_item          (q_out),
		.q_pop           (q_pop),
		.init_busy       (init_busy),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.flow_x          (flow_x),
		.flow_y          (flow_y),
		.warped_x        (warped_x),
		.warped_y        (warped_y),
		.warped_inside   (warped_inside),
		.original_inside (original_inside),
		.hit_count       (hit_count),
		.repeat_hit      (repeat_hit)
	);

endmodule

// ----- sv/eefc_ram.sv -----
`timescale 1ns / 1ps
module eefc_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/eefc_div.sv -----
`timescale 1ns / 1ps
module eefc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [2:0][eefc_pkg::DIV_W-1:0]       num,
	output logic                                  done,
	output logic [2:0][eefc_pkg::QUO_W-1:0]       quo
);
	import eefc_pkg::*;

	localparam logic [1:0] STG_MUL   = 2'd0;
	localparam logic [1:0] STG_SUM   = 2'd1;
	localparam logic [1:0] STG_QD    = 2'd2;
	localparam logic [1:0] STG_FIX   = 2'd3;
	localparam logic [1:0] LANE_LAST = 2'd2;
	localparam int HALF_W = DIV_W / 2;
	localparam int PROD_W = HALF_W + $bits(FOCAL_RECIP);
	localparam int QD_W   = QUO_W + $bits(FOCAL_Q);

	logic [1:0]            lane_q;
	logic [1:0]            stg_q;
	logic                  busy_q;
	logic                  done_q;
	logic [PROD_W-1:0]     ph_q;
	logic [PROD_W-1:0]     pl_q;
	logic [QUO_W-1:0]      qe_q;
	logic [QD_W-1:0]       qd_q;
	logic [2:0][QUO_W-1:0] quo_q;
	logic [DIV_W-1:0]      cur;
	logic [PROD_W:0]       qsum;
	logic [DIV_W-1:0]      rem;

	// division by the focal constant: multiply by its reciprocal, then one correction
	// step; lanes in turn (multiply, sum, product, fix), num held by the caller
	assign cur  = num[lane_q];
	assign qsum = (PROD_W+1)'(ph_q) + (PROD_W+1)'(pl_q[PROD_W-1:HALF_W]);
	assign rem  = cur - qd_q[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			lane_q <= '0;
			stg_q  <= STG_MUL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				lane_q <= '0;
				stg_q  <= STG_MUL;
			end else if (busy_q) begin
				stg_q <= stg_q + 2'd1;
				if (stg_q == STG_FIX) begin
					if (lane_q == LANE_LAST) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						lane_q <= lane_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			unique case (stg_q)
				STG_MUL: begin
					ph_q <= PROD_W'(cur[DIV_W-1:HALF_W]) * PROD_W'(FOCAL_RECIP);
					pl_q <= PROD_W'(cur[HALF_W-1:0]) * PROD_W'(FOCAL_RECIP);
				end
				STG_SUM: qe_q <= qsum[HALF_W +: QUO_W];
				STG_QD:  qd_q <= QD_W'(qe_q) * QD_W'(FOCAL_Q);
				STG_FIX: quo_q[lane_q] <= (rem >= DIV_W'(FOCAL_Q)) ? qe_q + 1'b1 : qe_q;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- sv/eefc_fifo.sv -----
`timescale 1ns / 1ps
module eefc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  eefc_pkg::eefc_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output eefc_pkg::eefc_item_t pop_item
);
	import eefc_pkg::*;

	eefc_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_item = mem_q[rd_ptr_q];

endmodule

// ----- sv/eefc_front.sv -----
`timescale 1ns / 1ps
module eefc_front #(
	parameter int IMAGE_WIDTH  = 304,
	parameter int IMAGE_HEIGHT = 240
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [8:0]           event_x,
	input  logic [7:0]           event_y,
	input  logic [31:0]          event_stamp,
	input  logic                 init_busy,
	input  logic                 q_full,
	output logic                 q_push,
	output eefc_pkg::eefc_item_t q_item
);
	import eefc_pkg::*;

	logic        ref_valid_q;
	logic [31:0] ref_stamp_q;
	logic [31:0] ref_use;

	assign in_ready = !q_full && !init_busy;
	assign q_push   = in_valid && in_ready;

	// first event of a batch is its own reference
	assign ref_use = ref_valid_q ? ref_stamp_q : event_stamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_valid_q <= 1'b0;
			ref_stamp_q <= '0;
		end else if (q_push) begin
			if (command) begin
				ref_valid_q <= 1'b0;
			end else if (!ref_valid_q) begin
				ref_valid_q <= 1'b1;
				ref_stamp_q <= event_stamp;
			end
		end
	end

	always_comb begin
		q_item.cmd  = command;
		q_item.x    = event_x;
		q_item.y    = event_y;
		q_item.diff = event_stamp - ref_use;
		q_item.dx   = $signed({1'b0, event_x, 16'b0}) - $signed({2'b0, PPX_Q});
		q_item.dy   = $signed({1'b0, event_y, 16'b0}) - $signed({1'b0, PPY_Q});
		q_item.o_in = (event_x != 9'd0) && (11'(event_x) < 11'(IMAGE_WIDTH - 1)) &&
			(event_y != 8'd0) && (11'(event_y) < 11'(IMAGE_HEIGHT - 1));
	end

endmodule

// ----- sv/eefc_back.sv -----
`timescale 1ns / 1ps
module eefc_back #(
	parameter int IMAGE_WIDTH  = 304,
	parameter int IMAGE_HEIGHT = 240
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eefc_pkg::eefc_cfg_t  cfg,
	input  logic                 q_empty,
	input  eefc_pkg::eefc_item_t q_item,
	output logic                 q_pop,
	output logic                 init_busy,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   flow_x,
	output logic signed [31:0]   flow_y,
	output logic signed [15:0]   warped_x,
	output logic signed [15:0]   warped_y,
	output logic                 warped_inside,
	output logic                 original_inside,
	output logic [7:0]           hit_count,
	output logic                 repeat_hit
);
	import eefc_pkg::*;

	localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(IMAGE_WIDTH);
	localparam int RW    = $clog2(IMAGE_HEIGHT);
	localparam logic signed [43:0] XLIM = 44'(longint'(IMAGE_WIDTH - 1) * 65536);
	localparam logic signed [43:0] YLIM = 44'(longint'(IMAGE_HEIGHT - 1) * 65536);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_ABC   = 4'd4;
	localparam logic [3:0] ST_FLOW  = 4'd5;
	localparam logic [3:0] ST_WARP  = 4'd6;
	localparam logic [3:0] ST_ADDR  = 4'd7;
	localparam logic [3:0] ST_RD    = 4'd8;
	localparam logic [3:0] ST_WR    = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	localparam logic [4:0] SP_DXDY = 5'd0;
	localparam logic [4:0] SP_DXDX = 5'd1;
	localparam logic [4:0] SP_DYDY = 5'd2;
	localparam logic [4:0] SP_AWX  = 5'd3;
	localparam logic [4:0] SP_BWY  = 5'd4;
	localparam logic [4:0] SP_DYWZ = 5'd5;
	localparam logic [4:0] SP_CWX  = 5'd6;
	localparam logic [4:0] SP_AWY  = 5'd7;
	localparam logic [4:0] SP_DXWZ = 5'd8;
	localparam logic [4:0] SP_FVX  = 5'd9;
	localparam logic [4:0] SP_DXVZ = 5'd10;
	localparam logic [4:0] SP_FVY  = 5'd11;
	localparam logic [4:0] SP_DYVZ = 5'd12;
	localparam logic [4:0] SP_SECS = 5'd13;
	localparam logic [4:0] SP_XHI  = 5'd14;
	localparam logic [4:0] SP_XLO  = 5'd15;
	localparam logic [4:0] SP_YHI  = 5'd16;
	localparam logic [4:0] SP_YLO  = 5'd17;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] s;
		s = v >>> 16;
		if (s > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (s < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return s[31:0];
	endfunction

	function automatic logic signed [15:0] trunc16(input logic signed [43:0] v);
		logic signed [43:0] t;
		t = v >>> 16;
		if (v[43] && (v[15:0] != 16'd0)) begin
			t = t + 44'sd1;
		end
		if (t > 44'sd32767) begin
			return 16'sh7fff;
		end else if (t < -44'sd32768) begin
			return 16'sh8000;
		end
		return t[15:0];
	endfunction

	logic [3:0]          state_q;
	logic [4:0]          step_q;
	logic                phase_q;
	logic                init_q;
	logic [AW-1:0]       clr_q;
	eefc_item_t          item_q;
	logic signed [65:0]  prod_q;
	logic signed [50:0]  pa_q;
	logic [49:0]         pb_q;
	logic [49:0]         pc_q;
	logic signed [27:0]  a_q;
	logic signed [27:0]  b_q;
	logic signed [27:0]  c_q;
	logic signed [63:0]  fx_q;
	logic signed [63:0]  fy_q;
	logic [63:0]         secs_q;
	logic signed [31:0]  flx_q;
	logic signed [31:0]  fly_q;
	logic [31:0]         magx_q;
	logic [31:0]         magy_q;
	logic [63:0]         dispx_q;
	logic [63:0]         dispy_q;
	logic signed [43:0]  xh_q;
	logic signed [43:0]  yh_q;
	logic                w_in_q;
	logic signed [15:0]  ox_q;
	logic signed [15:0]  oy_q;
	logic [AW-1:0]       addr_q;
	logic [7:0]          cnt_q;
	logic                div_go_q;

	logic                out_valid_q;
	logic signed [31:0]  res_fx_q;
	logic signed [31:0]  res_fy_q;
	logic signed [15:0]  res_wx_q;
	logic signed [15:0]  res_wy_q;
	logic                res_win_q;
	logic                res_oin_q;
	logic [7:0]          res_cnt_q;

	logic signed [32:0]  op_a;
	logic signed [32:0]  op_b;
	logic signed [63:0]  p;
	logic signed [63:0]  p2;
	logic [50:0]         pa_mag;
	logic                div_done;
	logic [2:0][DIV_W-1:0] div_num;
	logic [2:0][QUO_W-1:0] div_quo;
	logic signed [31:0]  flx_n;
	logic signed [31:0]  fly_n;
	logic [40:0]         dcx;
	logic [40:0]         dcy;
	logic signed [43:0]  posx;
	logic signed [43:0]  posy;
	logic                load_out;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;
	logic                ram_re;
	logic [7:0]          ram_rdata;
	logic [7:0]          cnt_inc;

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			SP_DXDY: begin op_a = {{7{item_q.dx[25]}}, item_q.dx};
				op_b = {{8{item_q.dy[24]}}, item_q.dy}; end
			SP_DXDX: begin op_a = {{7{item_q.dx[25]}}, item_q.dx};
				op_b = {{7{item_q.dx[25]}}, item_q.dx}; end
			SP_DYDY: begin op_a = {{8{item_q.dy[24]}}, item_q.dy};
				op_b = {{8{item_q.dy[24]}}, item_q.dy}; end
			SP_AWX:  begin op_a = {{5{a_q[27]}}, a_q}; op_b = {cfg.rvx[31], cfg.rvx}; end
			SP_BWY:  begin op_a = {{5{b_q[27]}}, b_q}; op_b = {cfg.rvy[31], cfg.rvy}; end
			SP_DYWZ: begin op_a = {{8{item_q.dy[24]}}, item_q.dy};
				op_b = {cfg.rvz[31], cfg.rvz}; end
			SP_CWX:  begin op_a = {{5{c_q[27]}}, c_q}; op_b = {cfg.rvx[31], cfg.rvx}; end
			SP_AWY:  begin op_a = {{5{a_q[27]}}, a_q}; op_b = {cfg.rvy[31], cfg.rvy}; end
			SP_DXWZ: begin op_a = {{7{item_q.dx[25]}}, item_q.dx};
				op_b = {cfg.rvz[31], cfg.rvz}; end
			SP_FVX:  begin op_a = {9'b0, FOCAL_Q}; op_b = {cfg.tvx[31], cfg.tvx}; end
			SP_DXVZ: begin op_a = {{7{item_q.dx[25]}}, item_q.dx};
				op_b = {cfg.tvz[31], cfg.tvz}; end
			SP_FVY:  begin op_a = {9'b0, FOCAL_Q}; op_b = {cfg.tvy[31], cfg.tvy}; end
			SP_DYVZ: begin op_a = {{8{item_q.dy[24]}}, item_q.dy};
				op_b = {cfg.tvz[31], cfg.tvz}; end
			SP_SECS: begin op_a = {1'b0, item_q.diff}; op_b = {1'b0, cfg.tick_scale}; end
			SP_XHI:  begin op_a = {1'b0, magx_q}; op_b = {1'b0, secs_q[63:32]}; end
			SP_XLO:  begin op_a = {1'b0, magx_q}; op_b = {1'b0, secs_q[31:0]}; end
			SP_YHI:  begin op_a = {1'b0, magy_q}; op_b = {1'b0, secs_q[63:32]}; end
			SP_YLO:  begin op_a = {1'b0, magy_q}; op_b = {1'b0, secs_q[31:0]}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign p      = $signed(prod_q[63:0]);
	assign p2     = p <<< 1;
	assign pa_mag = pa_q[50] ? 51'(-pa_q) : pa_q;

	assign div_num[0] = pa_mag[DIV_W-1:0];
	assign div_num[1] = pb_q;
	assign div_num[2] = pc_q;

	eefc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign flx_n = sat32(fx_q);
	assign fly_n = sat32(fy_q);
	assign dcx   = (dispx_q > 64'(DISP_CAP)) ? DISP_CAP : dispx_q[40:0];
	assign dcy   = (dispy_q > 64'(DISP_CAP)) ? DISP_CAP : dispy_q[40:0];
	assign posx  = $signed({19'b0, item_q.x, 16'b0});
	assign posy  = $signed({20'b0, item_q.y, 16'b0});

	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign cnt_inc  = ram_rdata + 8'd1;

	// count map port control: sweep while clearing, per event a read and, if warped inside, a write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = cnt_inc;
		ram_re    = state_q == ST_RD;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_WR) begin
			ram_we = w_in_q;
		end
	end

	eefc_ram #(
		.DATA_W (8),
		.DEPTH  (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= SP_DXDY;
			phase_q     <= 1'b0;
			init_q      <= 1'b1;
			clr_q       <= '0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_item.cmd) begin
							state_q <= ST_CLEAR;
							clr_q   <= '0;
						end else begin
							state_q <= ST_MUL;
							step_q  <= SP_DXDY;
							phase_q <= 1'b0;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						if (step_q == SP_DYDY) begin
							state_q  <= ST_DIV;
							div_go_q <= 1'b1;
						end else if (step_q == SP_SECS) begin
							state_q <= ST_FLOW;
						end else if (step_q == SP_YLO) begin
							state_q <= ST_WARP;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_ABC;
					end
				end
				ST_ABC: begin
					state_q <= ST_MUL;
					step_q  <= SP_AWX;
					phase_q <= 1'b0;
				end
				ST_FLOW: begin
					state_q <= ST_MUL;
					step_q  <= SP_XHI;
					phase_q <= 1'b0;
				end
				ST_WARP: state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_RD;
				ST_RD:   state_q <= ST_WR;
				ST_WR:   state_q <= ST_OUT;
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_MUL && !phase_q) begin
			prod_q <= op_a * op_b;
		end
		if (state_q == ST_MUL && phase_q) begin
			case (step_q)
				SP_DXDY: pa_q <= $signed(prod_q[50:0]);
				SP_DXDX: pb_q <= prod_q[49:0];
				SP_DYDY: pc_q <= prod_q[49:0];
				SP_AWX:  fx_q <= fx_q + p;
				SP_BWY:  fx_q <= fx_q - p;
				SP_DYWZ: fx_q <= fx_q + p;
				SP_CWX:  fy_q <= fy_q + p;
				SP_AWY:  fy_q <= fy_q - p;
				SP_DXWZ: fy_q <= fy_q - p;
				SP_FVX:  if (cfg.full_motion) fx_q <= fx_q - p2;
				SP_DXVZ: if (cfg.full_motion) fx_q <= fx_q + p2;
				SP_FVY:  if (cfg.full_motion) fy_q <= fy_q - p2;
				SP_DYVZ: if (cfg.full_motion) fy_q <= fy_q + p2;
				SP_SECS: secs_q <= prod_q[63:0];
				SP_XHI:  dispx_q <= prod_q[63:0];
				SP_XLO:  dispx_q <= dispx_q + 64'(prod_q[63:32]);
				SP_YHI:  dispy_q <= prod_q[63:0];
				SP_YLO:  dispy_q <= dispy_q + 64'(prod_q[63:32]);
				default: ;
			endcase
		end
		if (state_q == ST_ABC) begin
			a_q  <= pa_q[50] ? -$signed({1'b0, div_quo[0]}) : $signed({1'b0, div_quo[0]});
			b_q  <= $signed({1'b0, 27'(FOCAL_Q) + div_quo[1]});
			c_q  <= $signed({1'b0, 27'(FOCAL_Q) + div_quo[2]});
			fx_q <= '0;
			fy_q <= '0;
		end
		if (state_q == ST_FLOW) begin
			flx_q  <= flx_n;
			fly_q  <= fly_n;
			magx_q <= flx_n[31] ? (~flx_n + 32'd1) : flx_n;
			magy_q <= fly_n[31] ? (~fly_n + 32'd1) : fly_n;
		end
		if (state_q == ST_WARP) begin
			xh_q <= flx_q[31] ? posx + $signed({3'b0, dcx}) : posx - $signed({3'b0, dcx});
			yh_q <= fly_q[31] ? posy + $signed({3'b0, dcy}) : posy - $signed({3'b0, dcy});
		end
		if (state_q == ST_ADDR) begin
			w_in_q <= (xh_q > 44'sd0) && (xh_q < XLIM) && (yh_q > 44'sd0) && (yh_q < YLIM);
			ox_q   <= trunc16(xh_q);
			oy_q   <= trunc16(yh_q);
			addr_q <= AW'(yh_q[16 +: RW]) * AW'(IMAGE_WIDTH) + AW'(xh_q[16 +: CW]);
		end
		if (state_q == ST_WR) begin
			cnt_q <= w_in_q ? cnt_inc : 8'd0;
		end
		if (load_out) begin
			res_fx_q  <= flx_q;
			res_fy_q  <= fly_q;
			res_wx_q  <= ox_q;
			res_wy_q  <= oy_q;
			res_win_q <= w_in_q;
			res_oin_q <= item_q.o_in;
			res_cnt_q <= cnt_q;
		end
	end

	assign init_busy       = init_q;
	assign out_valid       = out_valid_q;
	assign flow_x          = res_fx_q;
	assign flow_y          = res_fy_q;
	assign warped_x        = res_wx_q;
	assign warped_y        = res_wy_q;
	assign warped_inside   = res_win_q;
	assign original_inside = res_oin_q;
	assign hit_count       = res_cnt_q;
	assign repeat_hit      = res_cnt_q > 8'd1;

endmodule

// ----- sv/eefc_checker.sv -----
`timescale 1ns / 1ps
module eefc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] flow_x,
	input logic signed [15:0] warped_x,
	input logic               warped_inside,
	input logic [7:0]         hit_count,
	input logic               repeat_hit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(flow_x) && $stable(warped_x) &&
			$stable(hit_count))
		else $error("result changed while stalled");

	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_hit == (hit_count > 8'd1))
		else $error("repeat flag disagrees with count");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !warped_inside |-> hit_count == 8'd0)
		else $error("count reported for warped position outside border");

endmodule

bind event_ego_flow_compensation_top eefc_checker u_chk (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import eefc_pkg::*;

	localparam int IMG_W = 304;
	localparam int IMG_H = 240;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int SWEEP_WAIT = IMG_W * IMG_H + 400;
	localparam int TAIL_WAIT = 200;

	// sender/receiver idling modes
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [31:0] flow_x;
		logic signed [31:0] flow_y;
		logic signed [15:0] warped_x;
		logic signed [15:0] warped_y;
		logic               warped_inside;
		logic               original_inside;
		logic [7:0]         hit_count;
		logic               repeat_hit;
	} flow_result_t;

	// predicts the compensation result of each event and holds the pending ones
	class flow_scoreboard;
		logic [31:0]   vel[6];
		logic          full_motion;
		logic [31:0]   tick_scale;
		byte unsigned  hits[IMG_W * IMG_H];
		logic [31:0]   ref_stamp;
		bit            ref_valid;
		flow_result_t  pending[$];
		int            errors;

		function new();
			foreach (vel[i]) vel[i] = '0;
			full_motion = 1'b1;
			tick_scale = 32'd344;
			foreach (hits[i]) hits[i] = 0;
			ref_stamp = '0;
			ref_valid = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [31:0] data);
			if (idx <= REG_ROT_VZ) vel[idx[2:0]] = data;
			else if (idx == REG_FULL_MOT) full_motion = data[0];
			else if (idx == REG_TICK_SCL) tick_scale = data;
		endfunction

		function longint warp_pos(longint pos, longint flow, longint unsigned secs);
			longint unsigned mag, disp;
			mag = (flow < 0) ? -flow : flow;
			disp = mag * (secs >> 32) + ((mag * (secs & 64'hFFFF_FFFF)) >> 32);
			if (disp > 64'h100_0000_0000) disp = 64'h100_0000_0000;
			return (flow < 0) ? pos + longint'(disp) : pos - longint'(disp);
		endfunction

		function longint sat(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function longint trunc16(longint v);
			return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
		endfunction

		function void note_input(logic cmd, logic [8:0] x, logic [7:0] y, logic [31:0] stamp);
			longint vx, vy, vz, wx, wy, wz, dx, dy, a, b, c, fx, fy, flx, fly, xh, yh;
			longint unsigned secs;
			logic [31:0] diff;
			int idx;
			flow_result_t r;
			if (cmd) begin
				foreach (hits[i]) hits[i] = 0;
				ref_valid = 0;
				return;
			end
			if (!ref_valid) begin
				ref_stamp = stamp;
				ref_valid = 1;
			end
			vx = longint'($signed(vel[0])); vy = longint'($signed(vel[1]));
			vz = longint'($signed(vel[2])); wx = longint'($signed(vel[3]));
			wy = longint'($signed(vel[4])); wz = longint'($signed(vel[5]));
			dx = longint'(x) * 65536 - longint'(PPX_Q);
			dy = longint'(y) * 65536 - longint'(PPY_Q);
			a = (dx * dy) / longint'(FOCAL_Q);
			b = longint'(FOCAL_Q) + (dx * dx) / longint'(FOCAL_Q);
			c = longint'(FOCAL_Q) + (dy * dy) / longint'(FOCAL_Q);
			fx = a * wx - b * wy + dy * wz;
			fy = c * wx - a * wy - dx * wz;
			if (full_motion) begin
				fx += -2 * longint'(FOCAL_Q) * vx + 2 * dx * vz;
				fy += -2 * longint'(FOCAL_Q) * vy + 2 * dy * vz;
			end
			flx = sat(fx >>> 16, -64'sd2147483648, 64'sd2147483647);
			fly = sat(fy >>> 16, -64'sd2147483648, 64'sd2147483647);
			diff = stamp - ref_stamp;
			secs = longint'(diff) * longint'(tick_scale);
			xh = warp_pos(longint'(x) * 65536, flx, secs);
			yh = warp_pos(longint'(y) * 65536, fly, secs);
			r.flow_x = flx[31:0];
			r.flow_y = fly[31:0];
			r.warped_inside = (xh > 0 && xh < (IMG_W - 1) * 65536 &&
				yh > 0 && yh < (IMG_H - 1) * 65536);
			r.original_inside = (x > 0 && x < IMG_W - 1 && y > 0 && y < IMG_H - 1);
			r.hit_count = 8'd0;
			if (r.warped_inside) begin
				idx = int'(yh >>> 16) * IMG_W + int'(xh >>> 16);
				hits[idx] = hits[idx] + 8'd1;
				r.hit_count = hits[idx];
			end
			r.repeat_hit = (r.hit_count > 1);
			xh = sat(trunc16(xh), -32768, 32767);
			yh = sat(trunc16(yh), -32768, 32767);
			r.warped_x = xh[15:0];
			r.warped_y = yh[15:0];
			pending = {pending, r};
		endfunction

		function void check_result(flow_result_t got);
			flow_result_t e;
			if (pending.size() == 0) begin
				$error("result with no event waiting");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.flow_x !== e.flow_x) begin
				$error("flow_x expected %0d got %0d", e.flow_x, got.flow_x); errors++;
			end
			if (got.flow_y !== e.flow_y) begin
				$error("flow_y expected %0d got %0d", e.flow_y, got.flow_y); errors++;
			end
			if (got.warped_x !== e.warped_x) begin
				$error("warped_x expected %0d got %0d", e.warped_x, got.warped_x); errors++;
			end
			if (got.warped_y !== e.warped_y) begin
				$error("warped_y expected %0d got %0d", e.warped_y, got.warped_y); errors++;
			end
			if (got.warped_inside !== e.warped_inside) begin
				$error("warped_inside expected %0d got %0d", e.warped_inside,
					got.warped_inside); errors++;
			end
			if (got.original_inside !== e.original_inside) begin
				$error("original_inside expected %0d got %0d", e.original_inside,
					got.original_inside); errors++;
			end
			if (got.hit_count !== e.hit_count) begin
				$error("hit_count expected %0d got %0d", e.hit_count, got.hit_count); errors++;
			end
			if (got.repeat_hit !== e.repeat_hit) begin
				$error("repeat_hit expected %0d got %0d", e.repeat_hit, got.repeat_hit); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic command = 1'b0;
	logic [8:0] event_x = '0;
	logic [7:0] event_y = '0;
	logic [31:0] event_stamp = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] flow_x, flow_y;
	logic signed [15:0] warped_x, warped_y;
	logic warped_inside, original_inside, repeat_hit;
	logic [7:0] hit_count;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	flow_scoreboard sb = new();
	idle_mode_t idle_mode = IDLE_NONE;
	int stall_watch = 0;
	bit batch_cleared = 0;    // a new-batch sweep may still be running
	logic [31:0] gen_stamp = '0;

	event_ego_flow_compensation_top u_top (.*);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure, depends on the phase's idling mode
	always @(posedge clk) begin
		if (idle_mode == IDLE_RECV) out_ready <= ($urandom_range(99) >= 51);
		else if (idle_mode == IDLE_BOTH) out_ready <= ($urandom_range(99) >= 28);
		else out_ready <= 1'b1;
	end

	// result monitor, values sampled before this edge's updates
	always @(posedge clk) begin
		flow_result_t got;
		if (out_valid && out_ready) begin
			got.flow_x = flow_x;
			got.flow_y = flow_y;
			got.warped_x = warped_x;
			got.warped_y = warped_y;
			got.warped_inside = warped_inside;
			got.original_inside = original_inside;
			got.hit_count = hit_count;
			got.repeat_hit = repeat_hit;
			sb.check_result(got);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_watch <= 0;
		else
			stall_watch <= stall_watch + 1;
		if (stall_watch >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one input transfer; valid is left high for the caller to drop or reuse
	task automatic send_item(logic cmd, logic [8:0] x, logic [7:0] y, logic [31:0] stamp);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SEND) ? 51 : ((idle_mode == IDLE_BOTH) ? 28 : 0);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		event_x <= x;
		event_y <= y;
		event_stamp <= stamp;
		do @(posedge clk); while (!in_ready);
		sb.note_input(cmd, x, y, stamp);
		if (cmd) batch_cleared = 1;
	endtask

	task automatic send_event(logic [8:0] x, logic [7:0] y, logic [31:0] stamp);
		send_item(1'b0, x, y, stamp);
	endtask

	// quiet point: all results back, sweep finished if one was started
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (batch_cleared ? SWEEP_WAIT : TAIL_WAIT) @(posedge clk);
		batch_cleared = 0;
	endtask

	task automatic write_config(logic [31:0] v[6], logic fm, logic [31:0] scale);
		logic [31:0] data;
		for (int i = 0; i < 8; i++) begin
			data = (i < 6) ? v[i] : ((i == 6) ? {31'd0, fm} : scale);
			cfg_valid <= 1'b1;
			cfg_index <= 4'(i);
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(4'(i), data);
		end
		cfg_valid <= 1'b0;
	endtask

	// random event or, rarely, a new-batch command; events mostly on the sensor, stamps mostly moving forward
	task automatic random_item();
		logic [8:0] x;
		logic [7:0] y;
		if ($urandom_range(249) == 0) begin
			send_item(1'b1, 9'($urandom), 8'($urandom), $urandom);
			return;
		end
		x = ($urandom_range(19) == 0) ? 9'($urandom) : 9'($urandom_range(IMG_W - 1));
		y = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(IMG_H - 1));
		if ($urandom_range(29) == 0) gen_stamp = $urandom;
		else gen_stamp = gen_stamp + $urandom_range(20000);
		send_event(x, y, gen_stamp);
	endtask

	initial begin
		logic [31:0] v[6];
		logic fm;
		logic [31:0] scale;
		int kind;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset configuration, plus rotation about y and translation along z
		foreach (v[i]) v[i] = '0;
		v[REG_ROT_VY] = 32'h0000_1000;
		v[REG_TRANS_VZ] = 32'h0000_0800;
		write_config(v, 1'b1, 32'd344);
		send_event(9'd152, 8'd120, 32'hFFFF_FF00);
		send_event(9'd0, 8'd0, 32'hFFFF_FFFF);          // stamp at the top of the 32-bit range
		send_event(9'd303, 8'd239, 32'd5000);
		send_event(9'd511, 8'd255, 32'd9000);           // beyond the image
		send_event(9'd1, 8'd1, 32'd0);
		send_event(9'd302, 8'd238, 32'hFFFF_0000);      // stamp before reference
		send_event(9'd152, 8'd120, 32'hFFFF_FF00);
		send_event(9'd152, 8'd120, 32'hFFFF_FF00);      // repeated pixel
		send_event(9'd304, 8'd240, 32'h0001_0000);
		send_item(1'b1, 9'd0, 8'd0, 32'd0);             // new batch
		send_event(9'd152, 8'd120, 32'h8000_0000);
		send_event(9'd152, 8'd120, 32'hFFFF_FFFF);
		send_event(9'h155, 8'haa, 32'h5555_5555);
		send_event(9'h0aa, 8'h55, 32'haaaa_aaaa);
		wait_drained();

		// count wrap: no motion, same pixel hit past 255
		foreach (v[i]) v[i] = '0;
		write_config(v, 1'b0, 32'd0);
		for (int i = 0; i < 300; i++) send_event(9'd40, 8'd30, $urandom);
		wait_drained();

		for (int p = 0; p < 12; p++) begin
			idle_mode = idle_mode_t'(p % 4);
			kind = p % 6;
			foreach (v[i]) begin
				case (kind)
					0: v[i] = 32'h7FFF_FFFF;
					1: v[i] = 32'h8000_0000;
					2: v[i] = $urandom;
					default: v[i] = 32'($signed($urandom_range(16384)) - 8192);
				endcase
			end
			fm = (p % 3 != 0);
			case (p % 4)
				0: scale = 32'hFFFF_FFFF;
				1: scale = 32'd1;
				2: scale = $urandom_range(4000, 1);
				default: scale = 32'd344;
			endcase
			write_config(v, fm, scale);
			for (int i = 0; i < 95; i++) begin
				random_item();
				// hold off once until everything issued has come back
				if (p == 5 && i == 40) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
			wait_drained();
		end

		idle_mode = IDLE_NONE;
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
